// File: sv/stnm_pkg.sv
// shared types and constants for the sorted table nearest match block
package stnm_pkg;

	// fixed field widths of the request, result and config channels
	localparam int POS_W      = 10;
	localparam int VAL_W      = 32;
	localparam int SIZE_W     = 11;
	localparam int MATCH_W    = 10;

	// default table depth
	localparam int TABLE_DEPTH_DEF = 1024;

	// request action codes
	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	// result kind codes
	localparam logic KIND_ACK    = 1'b0;
	localparam logic KIND_ANSWER = 1'b1;

	// search sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_END_LO,
		ST_END_HI,
		ST_BISECT,
		ST_PICK,
		ST_BACK,
		ST_DONE
	} st_t;

	// finished result handed to the output register
	typedef struct packed {
		logic [MATCH_W-1:0] nearest_idx;
		logic               kind;
	} res_t;

endpackage

// File: sv/stnm_table.sv
// cutoff table memory, one write port and one registered read port
module stnm_table #(
	parameter int TABLE_DEPTH = stnm_pkg::TABLE_DEPTH_DEF,
	localparam int IDX_W      = $clog2(TABLE_DEPTH)
) (
	input  logic                              clk,
	input  logic                              wr_en,
	input  logic [IDX_W-1:0]                  wr_addr,
	input  logic signed [stnm_pkg::VAL_W-1:0] wr_data,
	input  logic                              rd_en,
	input  logic [IDX_W-1:0]                  rd_addr,
	output logic signed [stnm_pkg::VAL_W-1:0] rd_data
);

	logic signed [stnm_pkg::VAL_W-1:0] mem_q [TABLE_DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// read port, data in the cycle after the address
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: sv/stnm_ctrl.sv
// search sequencer: end checks, bisection, nearest pick and step back over equal runs
module stnm_ctrl #(
	parameter int TABLE_DEPTH = stnm_pkg::TABLE_DEPTH_DEF,
	localparam int IDX_W      = $clog2(TABLE_DEPTH)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// request side
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               action,
	input  logic [stnm_pkg::POS_W-1:0]         position,
	input  logic signed [stnm_pkg::VAL_W-1:0]  value,
	input  logic [stnm_pkg::SIZE_W-1:0]        table_size,
	// table memory
	output logic                               wr_en,
	output logic [IDX_W-1:0]                   wr_addr,
	output logic signed [stnm_pkg::VAL_W-1:0]  wr_data,
	output logic                               rd_en,
	output logic [IDX_W-1:0]                   rd_addr,
	input  logic signed [stnm_pkg::VAL_W-1:0]  rd_data,
	// result side
	output logic                               res_valid,
	input  logic                               res_take,
	output stnm_pkg::res_t                     res
);

	localparam int CW = (IDX_W + 1 > stnm_pkg::SIZE_W) ? IDX_W + 1 : stnm_pkg::SIZE_W;
	localparam logic [IDX_W-1:0] ONE_I = 1;
	localparam logic [IDX_W:0]   ONE_X = 1;
	localparam logic [CW-1:0]    ONE_C = 1;
	localparam logic [CW-1:0]    DEP_C = CW'(TABLE_DEPTH);

	stnm_pkg::st_t state_q, state_d;

	logic signed [stnm_pkg::VAL_W-1:0] sample_q, lo_val_q, hi_val_q, best_val_q;
	logic [IDX_W-1:0] low_q, high_q, mid_q, best_q;
	logic             hit_q;
	logic             kind_q;

	logic             accept;
	logic [CW-1:0]    size_w, n_w, pos_w, best_w;
	logic [IDX_W-1:0] hi_init;
	logic             single, pos_ok;

	logic             eq_d, lt_d;
	logic [IDX_W-1:0] low_n, high_n, bl, bh, mid_n, bk_idx;
	logic [IDX_W:0]   sum;
	logic             more, hit_n, bk_nz, pick_low;
	logic signed [stnm_pkg::VAL_W:0] dl_s, dh_s;
	logic [stnm_pkg::VAL_W:0]        dl, dh;

	assign accept = in_valid && (state_q == stnm_pkg::ST_IDLE);

	// table size clamp and load position check
	always_comb begin
		size_w = CW'(table_size);
		if (size_w == '0) begin
			n_w = ONE_C;
		end else if (size_w > DEP_C) begin
			n_w = DEP_C;
		end else begin
			n_w = size_w;
		end
		hi_init = IDX_W'(n_w - ONE_C);
		single  = (n_w == ONE_C);
		pos_w   = CW'(position);
		pos_ok  = (pos_w < DEP_C);
	end

	// compares on the read data and bracket update
	always_comb begin
		eq_d   = (rd_data == sample_q);
		lt_d   = (rd_data < sample_q);
		low_n  = low_q;
		high_n = high_q;
		if (lt_d) begin
			low_n = mid_q;
		end else begin
			high_n = mid_q;
		end
		bl = low_q;
		bh = high_q;
		if (state_q == stnm_pkg::ST_BISECT) begin
			bl = low_n;
			bh = high_n;
		end
		sum   = {1'b0, bl} + {1'b0, bh};
		mid_n = sum[IDX_W:1];
		more  = (({1'b0, bl} + ONE_X) < {1'b0, bh});
		hit_n = hit_q || ((state_q == stnm_pkg::ST_BISECT) && eq_d);
	end

	// distances at 33 bits, tie goes to the upper entry
	always_comb begin
		dl_s     = {lo_val_q[stnm_pkg::VAL_W-1], lo_val_q}
			- {sample_q[stnm_pkg::VAL_W-1], sample_q};
		dh_s     = {hi_val_q[stnm_pkg::VAL_W-1], hi_val_q}
			- {sample_q[stnm_pkg::VAL_W-1], sample_q};
		dl       = dl_s[stnm_pkg::VAL_W] ? unsigned'(-dl_s) : unsigned'(dl_s);
		dh       = dh_s[stnm_pkg::VAL_W] ? unsigned'(-dh_s) : unsigned'(dh_s);
		pick_low = (dl < dh);
	end

	// candidate answer before stepping back
	always_comb begin
		case (state_q)
			stnm_pkg::ST_END_HI: bk_idx = high_q;
			stnm_pkg::ST_BISECT: bk_idx = eq_d ? mid_q : best_q;
			stnm_pkg::ST_PICK:   bk_idx = pick_low ? low_q : high_q;
			stnm_pkg::ST_BACK:   bk_idx = best_q - ONE_I;
			default:             bk_idx = best_q;
		endcase
		bk_nz = (bk_idx != '0);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			stnm_pkg::ST_IDLE: begin
				if (accept) begin
					if (action == stnm_pkg::ACT_LOAD || single) begin
						state_d = stnm_pkg::ST_DONE;
					end else begin
						state_d = stnm_pkg::ST_END_LO;
					end
				end
			end
			stnm_pkg::ST_END_LO: begin
				state_d = eq_d ? stnm_pkg::ST_DONE : stnm_pkg::ST_END_HI;
			end
			stnm_pkg::ST_END_HI: begin
				if (eq_d) begin
					state_d = bk_nz ? stnm_pkg::ST_BACK : stnm_pkg::ST_DONE;
				end else begin
					state_d = more ? stnm_pkg::ST_BISECT : stnm_pkg::ST_PICK;
				end
			end
			stnm_pkg::ST_BISECT: begin
				if (more) begin
					state_d = stnm_pkg::ST_BISECT;
				end else if (hit_n) begin
					state_d = bk_nz ? stnm_pkg::ST_BACK : stnm_pkg::ST_DONE;
				end else begin
					state_d = stnm_pkg::ST_PICK;
				end
			end
			stnm_pkg::ST_PICK: begin
				state_d = bk_nz ? stnm_pkg::ST_BACK : stnm_pkg::ST_DONE;
			end
			stnm_pkg::ST_BACK: begin
				state_d = (rd_data == best_val_q && bk_nz) ? stnm_pkg::ST_BACK
					: stnm_pkg::ST_DONE;
			end
			stnm_pkg::ST_DONE: begin
				if (res_take) begin
					state_d = stnm_pkg::ST_IDLE;
				end
			end
			default: state_d = stnm_pkg::ST_IDLE;
		endcase
	end

	// outputs: handshake, memory ports, result
	always_comb begin
		in_stall = (state_q != stnm_pkg::ST_IDLE);
		wr_en    = accept && (action == stnm_pkg::ACT_LOAD) && pos_ok;
		wr_addr  = pos_w[IDX_W-1:0];
		wr_data  = value;
		rd_en    = state_d inside {stnm_pkg::ST_END_LO, stnm_pkg::ST_END_HI,
			stnm_pkg::ST_BISECT, stnm_pkg::ST_BACK};
		case (state_d)
			stnm_pkg::ST_END_HI: rd_addr = high_q;
			stnm_pkg::ST_BISECT: rd_addr = mid_n;
			stnm_pkg::ST_BACK:   rd_addr = bk_idx - ONE_I;
			default:             rd_addr = '0;
		endcase
		res_valid       = (state_q == stnm_pkg::ST_DONE);
		best_w          = CW'(best_q);
		res.nearest_idx = best_w[stnm_pkg::MATCH_W-1:0];
		res.kind        = kind_q;
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stnm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// search datapath
	always_ff @(posedge clk) begin
		case (state_q)
			stnm_pkg::ST_IDLE: begin
				if (accept) begin
					sample_q <= value;
					kind_q   <= (action == stnm_pkg::ACT_LOAD) ? stnm_pkg::KIND_ACK
						: stnm_pkg::KIND_ANSWER;
					best_q   <= '0;
					hit_q    <= 1'b0;
					low_q    <= '0;
					high_q   <= hi_init;
				end
			end
			stnm_pkg::ST_END_LO: begin
				lo_val_q <= rd_data;
			end
			stnm_pkg::ST_END_HI: begin
				hi_val_q <= rd_data;
				mid_q    <= mid_n;
				if (eq_d) begin
					best_q     <= bk_idx;
					best_val_q <= sample_q;
				end
			end
			stnm_pkg::ST_BISECT: begin
				low_q  <= low_n;
				high_q <= high_n;
				mid_q  <= mid_n;
				hit_q  <= hit_n;
				best_q <= bk_idx;
				if (lt_d) begin
					lo_val_q <= rd_data;
				end else begin
					hi_val_q <= rd_data;
				end
				if (eq_d) begin
					best_val_q <= sample_q;
				end
			end
			stnm_pkg::ST_PICK: begin
				best_q     <= bk_idx;
				best_val_q <= pick_low ? lo_val_q : hi_val_q;
			end
			stnm_pkg::ST_BACK: begin
				if (rd_data == best_val_q) begin
					best_q <= bk_idx;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// File: sv/sorted_table_nearest_match_core.sv
// top level: size register, sequencer, cutoff table and result register
//
//  channel   signals                          direction  carries
//  request   in_valid in_stall action         in         load or query
//            position value
//  result    out_valid out_stall nearest_idx  out        ack or answer index
//            kind
//  config    cfg_wr_en cfg_wr_data            in         table_size
//
// a load writes the table at an in-range position and answers with an ack; a query
// checks both table ends, bisects, picks the nearer entry and steps back over a run of equal values
// every table read of the search waits on the single read port of the table memory
// reset sets table_size to 1; table contents are undefined until loaded, no clearing pass
// the result register lets the sequencer take the next request while a result is stalled
module sorted_table_nearest_match_core #(
	parameter int TABLE_DEPTH = stnm_pkg::TABLE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                action,
	input  logic [stnm_pkg::POS_W-1:0]          position,
	input  logic signed [stnm_pkg::VAL_W-1:0]   value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [stnm_pkg::MATCH_W-1:0]        nearest_idx,
	output logic                                kind,
	input  logic                                cfg_wr_en,
	input  logic [stnm_pkg::SIZE_W-1:0]         cfg_wr_data
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int AW    = IDX_W + 1;

	logic [stnm_pkg::SIZE_W-1:0]       table_size_q;
	logic                              wr_en, rd_en;
	logic [IDX_W-1:0]                  wr_addr, rd_addr;
	logic signed [stnm_pkg::VAL_W-1:0] wr_data, rd_data;
	logic                              res_valid, res_take;
	stnm_pkg::res_t                    res;
	logic                              out_valid_q;
	stnm_pkg::res_t                    out_q;

	// table size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= stnm_pkg::SIZE_W'(1);
		end else if (cfg_wr_en) begin
			table_size_q <= cfg_wr_data;
		end
	end

	stnm_ctrl #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.position   (position),
		.value      (value),
		.table_size (table_size_q),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.res_valid  (res_valid),
		.res_take   (res_take),
		.res        (res)
	);

	stnm_table #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// result register
	assign res_take = res_valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign nearest_idx = out_q.nearest_idx;
	assign kind        = out_q.kind;

	// a taken request makes the sequencer busy in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("sequencer ready right after a request");

	// load acknowledges carry index zero
	a_ack_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == stnm_pkg::KIND_ACK |-> nearest_idx == '0)
		else $error("load acknowledge with nonzero index");

	// table reads stay inside the memory
	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> AW'(rd_addr) < AW'(TABLE_DEPTH))
		else $error("table read beyond depth");

	// the table is never read and written in the same cycle
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_en && wr_en))
		else $error("table read and write overlap");

endmodule
